@@ hw/rtl/twmj_pkg.sv @@
// ----------------------------------------------------------------------------
// twmj_pkg: shared types and constants
// Item codes, register map, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package twmj_pkg;

    // default table size
    localparam int TABLE_DEPTH_DEF = 1024;

    // field widths
    localparam int STAMP_W  = 32;
    localparam int MAG_W    = 16;
    localparam int WINDOW_W = 24;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // register map and reset values
    localparam logic [APB_AW-1:0]   ADDR_MATCH_WINDOW  = 3'd0;
    localparam logic [WINDOW_W-1:0] MATCH_WINDOW_RESET = 24'd60;

    // item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear;
        logic query;
        logic scan_rd;
        logic capture;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic scan_last;
    } dp_status_t;

endpackage

@@ hw/rtl/twmj_ram.sv @@
// ----------------------------------------------------------------------------
// twmj_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module twmj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/twmj_ctrl.sv @@
// ----------------------------------------------------------------------------
// twmj_ctrl: sequencing controller
// Decodes incoming transactions and steps a query through the table scan.
// ----------------------------------------------------------------------------
module twmj_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           kind,
    input  twmj_pkg::dp_status_t status,
    output twmj_pkg::dp_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);
    import twmj_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.capture;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (kind)
                        KIND_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        KIND_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            cmd.query  = 1'b1;
                            state_next = status.empty ? ST_FINISH : ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

@@ hw/rtl/twmj_datapath.sv @@
// ----------------------------------------------------------------------------
// twmj_datapath: table storage and match datapath
// Holds the table RAM and fill count, walks the scan index and keeps the
// earliest in-window entry seen so far.
// ----------------------------------------------------------------------------
module twmj_datapath #(
    parameter int TABLE_DEPTH = twmj_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  twmj_pkg::dp_cmd_t                    cmd,
    output twmj_pkg::dp_status_t                 status,
    input  logic [twmj_pkg::WINDOW_W-1:0]        match_window,
    input  logic [twmj_pkg::STAMP_W-1:0]         stamp,
    input  logic signed [twmj_pkg::MAG_W-1:0]    magnitude,
    output logic [twmj_pkg::STAMP_W-1:0]         base_stamp,
    output logic signed [twmj_pkg::MAG_W-1:0]    base_magnitude,
    output logic signed [twmj_pkg::MAG_W-1:0]    partner_magnitude,
    output logic                                 matched
);
    import twmj_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ROW_W  = STAMP_W + MAG_W;

    logic [CNT_W-1:0]        count_reg;
    logic [ADDR_W-1:0]       idx_reg;
    logic                    rd_valid_reg;
    logic                    full;
    logic [ROW_W-1:0]        rdata;
    logic [STAMP_W-1:0]      entry_stamp;
    logic signed [MAG_W-1:0] entry_mag;
    logic [STAMP_W-1:0]      diff;
    logic                    in_window;
    logic                    better;

    logic [STAMP_W-1:0]      qstamp_reg;
    logic signed [MAG_W-1:0] qmag_reg;
    logic                    found_reg;
    logic [STAMP_W-1:0]      best_stamp_reg;
    logic signed [MAG_W-1:0] best_mag_reg;

    logic [STAMP_W-1:0]      out_stamp_reg;
    logic signed [MAG_W-1:0] out_mag_reg;
    logic signed [MAG_W-1:0] out_partner_reg;
    logic                    out_matched_reg;

    assign full             = (count_reg == CNT_W'(TABLE_DEPTH));
    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (CNT_W'(idx_reg) == (count_reg - CNT_W'(1)));

    // table storage, stamp in the upper bits
    twmj_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.load && !full),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({stamp, magnitude}),
        .re    (cmd.scan_rd),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // fill count, scan index and read-valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_rd;
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.load && !full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.query)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                idx_reg <= idx_reg + ADDR_W'(1);
            end
        end
    end

    // window test and earliest-stamp compare on the returned entry
    assign entry_stamp = rdata[ROW_W-1:MAG_W];
    assign entry_mag   = signed'(rdata[MAG_W-1:0]);
    assign diff        = (qstamp_reg >= entry_stamp) ? (qstamp_reg - entry_stamp)
                                                     : (entry_stamp - qstamp_reg);
    assign in_window   = (diff <= STAMP_W'(match_window));
    assign better      = !found_reg || (entry_stamp < best_stamp_reg);

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.query)
        begin
            found_reg <= 1'b0;
        end
        else if (rd_valid_reg && in_window)
        begin
            found_reg <= 1'b1;
        end
    end

    // query base and best candidate payload
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            qstamp_reg <= stamp;
            qmag_reg   <= magnitude;
        end
        if (rd_valid_reg && in_window && better)
        begin
            best_stamp_reg <= entry_stamp;
            best_mag_reg   <= entry_mag;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_stamp_reg   <= qstamp_reg;
            out_mag_reg     <= qmag_reg;
            out_partner_reg <= found_reg ? best_mag_reg : '0;
            out_matched_reg <= found_reg;
        end
    end

    assign base_stamp        = out_stamp_reg;
    assign base_magnitude    = out_mag_reg;
    assign partner_magnitude = out_partner_reg;
    assign matched           = out_matched_reg;

endmodule

@@ hw/rtl/time_window_match_join_core.sv @@
// ----------------------------------------------------------------------------
// time_window_match_join_core: time-window match join top level
// Loads (stamp, magnitude) entries into a table and answers queries with the
// earliest entry whose stamp lies within match_window of the query stamp.
//
//   channel   handshake                  payload
//   input     start / busy               kind, stamp, magnitude
//   result    done (one-cycle strobe)    base_stamp, base_magnitude,
//                                        partner_magnitude, matched
//   config    APB psel/penable/pwrite    paddr, pwdata, prdata
//
// load and clear transactions leave busy low.
// a query scans all N stored entries (none on an empty table):
// the scan reads one entry per cycle through the table RAM's single read port.
// done pulses in the first cycle with busy low; a new transaction may start then.
// reset empties the table (fill count only) and sets match_window to 60.
// results cannot be stalled; each one is valid for exactly its done cycle.
// ----------------------------------------------------------------------------
module time_window_match_join_core #(
    parameter int TABLE_DEPTH = twmj_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         kind,
    input  logic [twmj_pkg::STAMP_W-1:0]       stamp,
    input  logic signed [twmj_pkg::MAG_W-1:0]  magnitude,
    output logic                               done,
    output logic [twmj_pkg::STAMP_W-1:0]       base_stamp,
    output logic signed [twmj_pkg::MAG_W-1:0]  base_magnitude,
    output logic signed [twmj_pkg::MAG_W-1:0]  partner_magnitude,
    output logic                               matched,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [twmj_pkg::APB_AW-1:0]        paddr,
    input  logic [twmj_pkg::APB_DW-1:0]        pwdata,
    output logic [twmj_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import twmj_pkg::*;

    logic [WINDOW_W-1:0] match_window_reg;
    logic                cfg_write;
    logic                start_ok;
    dp_cmd_t             cmd;
    dp_status_t          status;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_window_reg <= MATCH_WINDOW_RESET;
        end
        else if (cfg_write && (paddr == ADDR_MATCH_WINDOW))
        begin
            match_window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_MATCH_WINDOW) ? APB_DW'(match_window_reg) : '0;

    // start only counts when the block is free
    assign start_ok = start && !busy;

    // controller
    twmj_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_ok),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath
    twmj_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .match_window      (match_window_reg),
        .stamp             (stamp),
        .magnitude         (magnitude),
        .base_stamp        (base_stamp),
        .base_magnitude    (base_magnitude),
        .partner_magnitude (partner_magnitude),
        .matched           (matched)
    );

    // a result only follows a busy query
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a preceding query");

    // the result strobe comes with the block free again
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while still busy");

    // an accepted query always occupies the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_QUERY)) |=> busy)
        else $error("query accepted but block not busy");

    // loads and clears never occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((kind == KIND_LOAD) || (kind == KIND_CLEAR))) |=> !busy)
        else $error("load or clear left the block busy");

endmodule
